[src/lmce_pkg.sv]
// ----------------------------------------------------------------------------
// lmce_pkg
// Shared types and constants for the LED matrix chain frame engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lmce_pkg;

  localparam int MAX_MODULES_DEF = 4;

  typedef enum logic [2:0] {
    OP_WRITE_COL = 3'd0,
    OP_SET_PIXEL = 3'd1,
    OP_CLEAR     = 3'd2,
    OP_ROTATE    = 3'd3,
    OP_COMMIT    = 3'd4,
    OP_SEND_ONE  = 3'd5,
    OP_SEND_ALL  = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ROT_NONE = 2'd0,
    ROT_90   = 2'd1,
    ROT_180  = 2'd2,
    ROT_270  = 2'd3
  } rot_mode_t;

  typedef struct packed {
    logic      cap;
    logic [2:0] cap_idx;
    logic [2:0] out_idx;
    rot_mode_t mode;
  } rot_ctl_t;

endpackage

`default_nettype wire

[src/led_matrix_chain_frame_engine.sv]
// ----------------------------------------------------------------------------
// led_matrix_chain_frame_engine
// Column store and frame sequencer for a daisy chain of 8x8 LED modules.
//
// Commands enter on the item channel (item_valid / item_stall); frames leave
// on the frame channel (frame_valid / frame_stall) through an output register.
// A frame carries one register/data pair in its module slot, zeros elsewhere;
// last marks the final frame of a command. Settings go through the APB port
// (module_count at 0x0, rotation_mode at 0x4); the user must write them only
// while the engine is idle, which the block itself does not enforce.
// Work per command, n = modules in use:
//   write column, clear, ignored ops: done in the idle state
//   set pixel: read-modify-write through the store's read port
//   rotate: per module, eight column reads into the shared rotation unit, then
//           eight write-backs of the turned columns
//   commit: 8*n frames; send one / send all: one frame, or one per module
// The next command is taken as soon as the last frame sits in the output
// register. A stalled receiver holds the sequencer in the frame it is on.
// Reset empties the store at once through per-column valid flags and sets
// one module, no rotation.
// ----------------------------------------------------------------------------
`default_nettype none

module led_matrix_chain_frame_engine #(
  parameter int MAX_MODULES = lmce_pkg::MAX_MODULES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [2:0]  op,
  input  logic [4:0]  column,
  input  logic [7:0]  value,
  input  logic [2:0]  pixel_row,
  input  logic [1:0]  module_index,
  input  logic [7:0]  reg_addr,
  output logic        frame_valid,
  input  logic        frame_stall,
  output logic [63:0] frame,
  output logic [3:0]  frame_bytes,
  output logic        last
);

  import lmce_pkg::*;

  localparam int DEPTH = 8 * MAX_MODULES;
  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [2:0] MAX_N = 3'(MAX_MODULES);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PX_WAIT,
    S_PX_DATA,
    S_RO_WAIT,
    S_RO_CAP,
    S_RO_WR,
    S_CM_WAIT,
    S_CM_DATA,
    S_SEND
  } state_t;

  state_t     state;
  logic [2:0] module_count;
  rot_mode_t  rotation_mode;
  logic [2:0] n_use;
  logic [2:0] n_item;
  logic [4:0] col_i;
  logic [2:0] wcnt;
  logic [2:0] prow;
  logic [7:0] snd_reg;
  logic [7:0] snd_data;
  logic       snd_one;
  logic [DEPTH-1:0] vld;
  logic       rd_vld;

  logic             accept;
  logic             in_range;
  logic             slot_last;
  logic             out_free;
  logic [7:0]       rdata;
  logic [7:0]       rd_z;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  rot_ctl_t         rot_ctl;
  logic [7:0]       rot_col;
  logic             em_go;
  logic [1:0]       em_slot;
  logic [7:0]       em_reg;
  logic [7:0]       em_data;
  logic             em_last;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      module_count  <= 3'd1;
      rotation_mode <= ROT_NONE;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) begin
        rotation_mode <= rot_mode_t'(pwdata[1:0]);
      end else begin
        module_count <= pwdata[2:0];
      end
    end
  end

  always_comb begin
    if (paddr[2]) begin
      prdata = {30'd0, rotation_mode};
    end else begin
      prdata = {29'd0, module_count};
    end
  end

  always_comb begin
    priority if (module_count == 3'd0) begin
      n_use = 3'd1;
    end else if (module_count > MAX_N) begin
      n_use = MAX_N;
    end else begin
      n_use = module_count;
    end
  end

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign in_range   = {1'b0, column[4:3]} < n_use;
  assign slot_last  = (col_i[4:3] == 2'(n_item - 3'd1));
  assign out_free   = !frame_valid || !frame_stall;
  assign rd_z       = rd_vld ? rdata : 8'd0;

  lmce_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(col_i[IDX_W-1:0]),
    .rdata(rdata)
  );

  always_comb begin
    rot_ctl.cap     = (state == S_RO_CAP);
    rot_ctl.cap_idx = col_i[2:0];
    rot_ctl.out_idx = wcnt;
    rot_ctl.mode    = rotation_mode;
  end

  lmce_rot u_rot (
    .clk     (clk),
    .ctl     (rot_ctl),
    .cap_data(rd_z),
    .out_col (rot_col)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = col_i[IDX_W-1:0];
    ram_wdata = rd_z | (8'd1 << prow);
    unique case (state)
      S_IDLE: begin
        if (accept && op == OP_WRITE_COL && in_range) begin
          ram_we    = 1'b1;
          ram_waddr = column[IDX_W-1:0];
          ram_wdata = value;
        end
      end
      S_PX_DATA: begin
        ram_we = 1'b1;
      end
      S_RO_WR: begin
        ram_we    = 1'b1;
        ram_waddr = IDX_W'({col_i[4:3], wcnt});
        ram_wdata = rot_col;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    em_go   = 1'b0;
    em_slot = col_i[4:3];
    em_reg  = snd_reg;
    em_data = snd_data;
    em_last = snd_one || slot_last;
    unique case (state)
      S_CM_DATA: begin
        em_go   = out_free;
        em_reg  = {5'd0, col_i[2:0]} + 8'd1;
        em_data = rd_z;
        em_last = (col_i[2:0] == 3'd7) && slot_last;
      end
      S_SEND: begin
        em_go = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      frame_valid <= 1'b0;
      vld         <= '0;
    end else begin
      rd_vld <= vld[col_i[IDX_W-1:0]];
      if (em_go) begin
        frame_valid <= 1'b1;
        frame       <= 64'({em_data, em_reg}) << {em_slot, 4'b0000};
        frame_bytes <= {n_item, 1'b0};
        last        <= em_last;
      end else if (frame_valid && !frame_stall) begin
        frame_valid <= 1'b0;
      end
      if (ram_we) begin
        vld[ram_waddr] <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            n_item   <= n_use;
            snd_reg  <= reg_addr;
            snd_data <= value;
            prow     <= pixel_row;
            unique case (op)
              OP_SET_PIXEL: begin
                if (in_range) begin
                  col_i <= column;
                  state <= S_PX_WAIT;
                end
              end
              OP_CLEAR: begin
                for (int i = 0; i < DEPTH; i++) begin
                  if (6'(i) < {n_use, 3'b000}) begin
                    vld[i] <= 1'b0;
                  end
                end
              end
              OP_ROTATE: begin
                if (rotation_mode != ROT_NONE) begin
                  col_i <= 5'd0;
                  state <= S_RO_WAIT;
                end
              end
              OP_COMMIT: begin
                col_i <= 5'd0;
                state <= S_CM_WAIT;
              end
              OP_SEND_ONE: begin
                if ({1'b0, module_index} < n_use) begin
                  col_i   <= {module_index, 3'b000};
                  snd_one <= 1'b1;
                  state   <= S_SEND;
                end
              end
              OP_SEND_ALL: begin
                col_i   <= 5'd0;
                snd_one <= 1'b0;
                state   <= S_SEND;
              end
              default: begin
              end
            endcase
          end
        end
        S_PX_WAIT: state <= S_PX_DATA;
        S_PX_DATA: state <= S_IDLE;
        S_RO_WAIT: state <= S_RO_CAP;
        S_RO_CAP: begin
          if (col_i[2:0] == 3'd7) begin
            wcnt  <= 3'd0;
            state <= S_RO_WR;
          end else begin
            col_i <= col_i + 5'd1;
            state <= S_RO_WAIT;
          end
        end
        S_RO_WR: begin
          wcnt <= wcnt + 3'd1;
          if (wcnt == 3'd7) begin
            if (slot_last) begin
              state <= S_IDLE;
            end else begin
              col_i <= col_i + 5'd1;
              state <= S_RO_WAIT;
            end
          end
        end
        S_CM_WAIT: state <= S_CM_DATA;
        S_CM_DATA: begin
          if (out_free) begin
            if (em_last) begin
              state <= S_IDLE;
            end else begin
              col_i <= col_i + 5'd1;
              state <= S_CM_WAIT;
            end
          end
        end
        S_SEND: begin
          if (out_free) begin
            if (em_last) begin
              state <= S_IDLE;
            end else begin
              col_i <= col_i + 5'd8;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_slot: assert property (@(posedge clk) disable iff (rst)
    frame_valid |-> $onehot0({|frame[63:48], |frame[47:32], |frame[31:16], |frame[15:0]}))
    else $error("frame fills more than one slot");

  a_slot_in_use: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> ({1'b0, col_i[4:3]} < n_item))
    else $error("sequencer outside the modules in use");

  a_bytes_even: assert property (@(posedge clk) disable iff (rst)
    frame_valid |-> (frame_bytes[0] == 1'b0 && frame_bytes != 4'd0))
    else $error("frame byte count malformed");

endmodule

`default_nettype wire

[src/lmce_ram.sv]
// ----------------------------------------------------------------------------
// lmce_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lmce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/lmce_rot.sv]
// ----------------------------------------------------------------------------
// lmce_rot
// Rotation unit: gathers the eight columns of one module, then hands back
// one turned column at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module lmce_rot (
  input  logic              clk,
  input  lmce_pkg::rot_ctl_t ctl,
  input  logic [7:0]        cap_data,
  output logic [7:0]        out_col
);

  import lmce_pkg::*;

  logic [7:0] cols_q [8];

  always_ff @(posedge clk) begin
    if (ctl.cap) begin
      cols_q[ctl.cap_idx] <= cap_data;
    end
  end

  always_comb begin
    out_col = 8'd0;
    for (int k = 0; k < 8; k++) begin
      unique case (ctl.mode)
        ROT_90:   out_col[k] = cols_q[3'(7 - k)][ctl.out_idx];
        ROT_180:  out_col[k] = cols_q[3'd7 - ctl.out_idx][3'(7 - k)];
        ROT_270:  out_col[k] = cols_q[3'(k)][3'd7 - ctl.out_idx];
        ROT_NONE: out_col[k] = cols_q[ctl.out_idx][k];
      endcase
    end
  end

endmodule

`default_nettype wire

[sim/tb_led_matrix_chain_frame_engine.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_led_matrix_chain_frame_engine
// Self-checking bench for the LED matrix chain frame engine. Commands go in on
// the item channel with random gaps. Frames are checked one by one against a
// column store model kept in the bench, including slot layout, byte count and
// last. The sink stalls at random and once holds off long enough to back up
// the engine. Settings change over the APB port between phases.
// ----------------------------------------------------------------------------
module tb_led_matrix_chain_frame_engine;
  import lmce_pkg::*;

  localparam int         MODS              = MAX_MODULES_DEF;
  localparam logic [2:0] OP_UNUSED         = 3'd7;
  localparam logic [2:0] ADDR_MODULE_COUNT = 3'h0;
  localparam logic [2:0] ADDR_ROTATION     = 3'h4;
  localparam int         DRAIN_CYCLES      = 24 * MODS + 16;
  localparam int         LONG_HOLD         = 400;
  localparam int         QUIET_LIMIT       = 4000;

  typedef struct packed {
    logic [63:0] frame;
    logic [3:0]  nbytes;
    logic        last;
  } chain_frame_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [2:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        item_valid   = 1'b0;
  logic        item_stall;
  logic [2:0]  op           = '0;
  logic [4:0]  column       = '0;
  logic [7:0]  value        = '0;
  logic [2:0]  pixel_row    = '0;
  logic [1:0]  module_index = '0;
  logic [7:0]  reg_addr     = '0;
  logic        frame_valid;
  logic        frame_stall  = 1'b0;
  logic [63:0] frame;
  logic [3:0]  frame_bytes;
  logic        last;

  logic [7:0]   col_store [32];
  logic [2:0]   cfg_modules;
  rot_mode_t    cfg_rotation;
  chain_frame_t frames_due [$];
  int           mismatches   = 0;
  int           quiet_cycles = 0;
  int           sink_hold    = 0;
  bit           idle_on      = 1'b1;

  led_matrix_chain_frame_engine u_dut (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic int unsigned mods_in_use();
    int unsigned n;
    n = cfg_modules;
    if (n < 1) n = 1;
    if (n > MODS) n = MODS;
    return n;
  endfunction

  function automatic void turn_module(int unsigned m, rot_mode_t mode);
    logic [7:0] src [8];
    logic [7:0] dst [8];
    for (int c = 0; c < 8; c++) begin
      src[c] = col_store[8 * m + c];
      dst[c] = 8'h00;
    end
    for (int c = 0; c < 8; c++) begin
      for (int r = 0; r < 8; r++) begin
        case (mode)
          ROT_90:  dst[r][7 - c]     = src[c][r];
          ROT_180: dst[7 - c][7 - r] = src[c][r];
          ROT_270: dst[r][c]         = src[c][7 - r];
          default: ;
        endcase
      end
    end
    for (int c = 0; c < 8; c++) col_store[8 * m + c] = dst[c];
  endfunction

  function automatic void push_frame(int unsigned slot, logic [7:0] ra, logic [7:0] data,
                                     int unsigned n, logic fin);
    chain_frame_t f;
    f.frame  = (64'(ra) << (16 * slot)) | (64'(data) << (16 * slot + 8));
    f.nbytes = 4'(2 * n);
    f.last   = fin;
    frames_due.push_back(f);
  endfunction

  function automatic void predict_frames(logic [2:0] op_code, logic [4:0] col,
                                         logic [7:0] val, logic [2:0] row,
                                         logic [1:0] midx, logic [7:0] ra);
    int unsigned n;
    int unsigned cols;
    n    = mods_in_use();
    cols = 8 * n;
    case (op_code)
      OP_WRITE_COL: if (col < cols) col_store[col] = val;
      OP_SET_PIXEL: if (col < cols) col_store[col][row] = 1'b1;
      OP_CLEAR:     for (int i = 0; i < cols; i++) col_store[i] = 8'h00;
      OP_ROTATE: begin
        if (cfg_rotation != ROT_NONE)
          for (int m = 0; m < n; m++) turn_module(m, cfg_rotation);
      end
      OP_COMMIT: begin
        for (int i = 0; i < cols; i++)
          push_frame(i / 8, 8'(i % 8 + 1), col_store[i], n, i + 1 == cols);
      end
      OP_SEND_ONE:  if (midx < n) push_frame(midx, ra, val, n, 1'b1);
      OP_SEND_ALL:  for (int i = 0; i < n; i++) push_frame(i, ra, val, n, i + 1 == n);
      default: ;
    endcase
  endfunction

  // frame check
  always @(posedge clk) begin : frame_check
    chain_frame_t want;
    if (!rst && frame_valid && !frame_stall) begin
      if (frames_due.size() == 0) begin
        report_mismatch("unexpected frame", frame, 64'd0);
      end else begin
        want = frames_due.pop_front();
        if (frame !== want.frame) report_mismatch("frame", frame, want.frame);
        if (frame_bytes !== want.nbytes)
          report_mismatch("frame_bytes", 64'(frame_bytes), 64'(want.nbytes));
        if (last !== want.last) report_mismatch("last", 64'(last), 64'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (frame_valid && !frame_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_led_matrix_chain_frame_engine NOT OK");
      $finish;
    end
  end

  // frame sink: random stall per transfer, long hold on request
  initial begin : frame_sink
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (sink_hold > 0) begin
        gap       = sink_hold;
        sink_hold = 0;
      end else begin
        gap = idle_on ? $urandom_range(0, 11) : 0;
      end
      if (gap > 0) begin
        frame_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      frame_stall <= 1'b0;
      do @(posedge clk); while (!frame_valid);
    end
  end

  task automatic send_item(logic [2:0] op_code, logic [4:0] col, logic [7:0] val,
                           logic [2:0] row, logic [1:0] midx, logic [7:0] ra);
    int gap;
    gap = idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid   <= 1'b1;
    op           <= op_code;
    column       <= col;
    value        <= val;
    pixel_row    <= row;
    module_index <= midx;
    reg_addr     <= ra;
    do @(posedge clk); while (item_stall);
    predict_frames(op_code, col, val, row, midx, ra);
  endtask

  // drain all frames, then let a rotate still in flight finish
  task automatic settle();
    item_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_MODULE_COUNT) cfg_modules = data[2:0];
    else cfg_rotation = rot_mode_t'(data[1:0]);
    // read back through the same select
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_MODULE_COUNT) begin
      want = 32'(cfg_modules);
      if (prdata[2:0] !== want[2:0])
        report_mismatch("module_count readback", 64'(prdata[2:0]), 64'(want[2:0]));
    end else begin
      want = 32'(cfg_rotation);
      if (prdata[1:0] !== want[1:0])
        report_mismatch("rotation_mode readback", 64'(prdata[1:0]), 64'(want[1:0]));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_settings(logic [2:0] mc, logic [1:0] rm);
    settle();
    apb_write(ADDR_MODULE_COUNT, 32'(mc));
    apb_write(ADDR_ROTATION, 32'(rm));
  endtask

  task automatic send_random_item();
    int unsigned pick;
    int unsigned n;
    logic [2:0]  op_code;
    logic [4:0]  col;
    pick = $urandom_range(0, 99);
    n    = mods_in_use();
    if (pick < 30)      op_code = OP_WRITE_COL;
    else if (pick < 45) op_code = OP_SET_PIXEL;
    else if (pick < 49) op_code = OP_CLEAR;
    else if (pick < 58) op_code = OP_ROTATE;
    else if (pick < 68) op_code = OP_COMMIT;
    else if (pick < 80) op_code = OP_SEND_ONE;
    else if (pick < 94) op_code = OP_SEND_ALL;
    else                op_code = OP_UNUSED;
    if ($urandom_range(0, 4) != 0) col = 5'($urandom_range(0, 8 * n - 1));
    else col = 5'($urandom_range(0, 31));
    send_item(op_code, col, 8'($urandom), 3'($urandom), 2'($urandom), 8'($urandom));
  endtask

  task automatic test_reset_defaults();
    send_item(OP_COMMIT, 5'd0, 8'h00, 3'd0, 2'd0, 8'h00);
    send_item(OP_SEND_ALL, 5'd0, 8'h00, 3'd0, 2'd0, 8'hFF);
  endtask

  task automatic test_column_edges();
    send_item(OP_WRITE_COL, 5'd0, 8'hFF, 3'd0, 2'd0, 8'h00);
    send_item(OP_WRITE_COL, 5'd7, 8'h80, 3'd0, 2'd0, 8'h00);
    send_item(OP_WRITE_COL, 5'd8, 8'h55, 3'd0, 2'd0, 8'h00);
    send_item(OP_WRITE_COL, 5'd31, 8'hAA, 3'd0, 2'd0, 8'h00);
    send_item(OP_SET_PIXEL, 5'd3, 8'h00, 3'd7, 2'd0, 8'h00);
    send_item(OP_SET_PIXEL, 5'd3, 8'h00, 3'd0, 2'd0, 8'h00);
    send_item(OP_SET_PIXEL, 5'd31, 8'h00, 3'd5, 2'd0, 8'h00);
    send_item(OP_COMMIT, 5'd0, 8'h00, 3'd0, 2'd0, 8'h00);
    program_settings(3'd4, ROT_NONE);
    send_item(OP_WRITE_COL, 5'd31, 8'hA5, 3'd0, 2'd3, 8'hFF);
    send_item(OP_WRITE_COL, 5'd16, 8'h5A, 3'd0, 2'd0, 8'h00);
    send_item(OP_SET_PIXEL, 5'd24, 8'h00, 3'd3, 2'd0, 8'h00);
    send_item(OP_COMMIT, 5'd0, 8'h00, 3'd0, 2'd0, 8'h00);
  endtask

  task automatic test_register_sends();
    send_item(OP_SEND_ONE, 5'd0, 8'hFF, 3'd0, 2'd0, 8'h00);
    send_item(OP_SEND_ONE, 5'd31, 8'h00, 3'd7, 2'd3, 8'hFF);
    send_item(OP_SEND_ALL, 5'd0, 8'h01, 3'd0, 2'd0, 8'h0C);
    send_item(OP_UNUSED, 5'd31, 8'hFF, 3'd7, 2'd3, 8'hFF);
    program_settings(3'd2, ROT_NONE);
    send_item(OP_SEND_ONE, 5'd0, 8'h3C, 3'd0, 2'd3, 8'h0F);
    send_item(OP_SEND_ONE, 5'd0, 8'hC3, 3'd0, 2'd1, 8'h09);
  endtask

  task automatic test_partial_clear();
    send_item(OP_CLEAR, 5'd0, 8'h00, 3'd0, 2'd0, 8'h00);
    send_item(OP_COMMIT, 5'd0, 8'h00, 3'd0, 2'd0, 8'h00);
    program_settings(3'd4, ROT_NONE);
    send_item(OP_COMMIT, 5'd0, 8'h00, 3'd0, 2'd0, 8'h00);
  endtask

  task automatic test_rotation();
    logic [2:0] mc_list [4] = '{3'd4, 3'd3, 3'd1, 3'd2};
    int unsigned n;
    for (int k = 0; k < 4; k++) begin
      program_settings(mc_list[k], 2'((k + 1) % 4));
      n = mods_in_use();
      repeat (4) send_item(OP_WRITE_COL, 5'($urandom_range(0, 8 * n - 1)), 8'($urandom),
                           3'd0, 2'd0, 8'h00);
      send_item(OP_SET_PIXEL, 5'($urandom_range(0, 8 * n - 1)), 8'h00, 3'($urandom),
                2'd0, 8'h00);
      send_item(OP_ROTATE, 5'd0, 8'h00, 3'd0, 2'd0, 8'h00);
      send_item(OP_COMMIT, 5'd0, 8'h00, 3'd0, 2'd0, 8'h00);
    end
  endtask

  task automatic test_backpressure();
    program_settings(3'd4, ROT_NONE);
    idle_on   = 1'b0;
    sink_hold = LONG_HOLD;
    send_item(OP_COMMIT, 5'd0, 8'h00, 3'd0, 2'd0, 8'h00);
    send_item(OP_SEND_ALL, 5'd0, 8'h7E, 3'd0, 2'd0, 8'h0A);
    send_item(OP_COMMIT, 5'd0, 8'h00, 3'd0, 2'd0, 8'h00);
    send_item(OP_SEND_ALL, 5'd0, 8'h81, 3'd0, 2'd0, 8'h0B);
    send_item(OP_COMMIT, 5'd0, 8'h00, 3'd0, 2'd0, 8'h00);
    settle();
    idle_on = 1'b1;
  endtask

  task automatic test_random_phases();
    logic [2:0] mc_list [8] = '{3'd1, 3'd4, 3'd7, 3'd0, 3'd2, 3'd3, 3'd5, 3'd4};
    logic [1:0] rm_list [8] = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd1, 2'd3, 2'd2, 2'd0};
    for (int p = 0; p < 8; p++) begin
      program_settings(mc_list[p], rm_list[p]);
      for (int i = 0; i < 12; i++) begin
        if (i % 6 == 0) idle_on = ($urandom_range(0, 3) != 0);
        send_random_item();
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < 32; i++) col_store[i] = 8'h00;
    cfg_modules  = 3'd1;
    cfg_rotation = ROT_NONE;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_column_edges();
    test_register_sends();
    test_partial_clear();
    test_rotation();
    test_backpressure();
    test_random_phases();
    settle();
    if (mismatches == 0)
      $display("tb_led_matrix_chain_frame_engine OK");
    else
      $display("tb_led_matrix_chain_frame_engine NOT OK");
    $finish;
  end

endmodule
